// File: sv/smm_pkg.sv
`default_nettype none

package smm_pkg;

  localparam int DATA_W    = 32;
  localparam int MAX_COUNT = 128;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int SUM_W     = DATA_W + $clog2(MAX_COUNT);
  localparam int OUT_CNT_W = 8;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int STEP_W    = $clog2(SUM_W);

  // One finished set, handed from the accumulator to the divide stage.
  typedef struct packed {
    logic signed [DATA_W-1:0] min_v;
    logic signed [DATA_W-1:0] max_v;
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         cnt;
    logic                     ovf;
  } smm_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } smm_qstat_t;

endpackage

`default_nettype wire

// File: sv/smm_front.sv
`default_nettype none

module smm_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                accept,
  input  wire logic signed [smm_pkg::DATA_W-1:0]   sample,
  input  wire logic                                last_item,
  output logic                                     push,
  output smm_pkg::smm_rec_t                        rec
);

  logic signed [smm_pkg::DATA_W-1:0] min_r, min_nxt;
  logic signed [smm_pkg::DATA_W-1:0] max_r, max_nxt;
  logic signed [smm_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [smm_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                              ovf_r, ovf_nxt;
  logic                              room;
  logic                              first;

  assign room  = cnt_r < smm_pkg::CNT_W'(smm_pkg::MAX_COUNT);
  assign first = cnt_r == '0;

  // Updated statistics including the current sample; once the set is full, only the overflow flag is set.
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (room) begin
      if (first || sample < min_r) begin
        min_nxt = sample;
      end
      if (first || sample > max_r) begin
        max_nxt = sample;
      end
      sum_nxt = sum_r + smm_pkg::SUM_W'(sample);
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  assign push      = accept && last_item;
  assign rec.min_v = min_nxt;
  assign rec.max_v = max_nxt;
  assign rec.sum   = sum_nxt;
  assign rec.cnt   = cnt_nxt;
  assign rec.ovf   = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (last_item) begin
        sum_r <= '0;
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/smm_queue.sv
`default_nettype none

module smm_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  smm_pkg::smm_rec_t       wr_rec,
  input  wire logic               pop,
  output smm_pkg::smm_rec_t       rd_rec,
  output smm_pkg::smm_qstat_t     qstat
);

  smm_pkg::smm_rec_t            mem_r [smm_pkg::Q_DEPTH];
  logic [smm_pkg::Q_AW-1:0]     wr_ptr_r;
  logic [smm_pkg::Q_AW-1:0]     rd_ptr_r;
  logic [smm_pkg::Q_AW:0]       fill_r;

  function automatic logic [smm_pkg::Q_AW-1:0] ptr_inc(input logic [smm_pkg::Q_AW-1:0] p);
    if (p == smm_pkg::Q_AW'(smm_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign qstat.full  = fill_r == (smm_pkg::Q_AW + 1)'(smm_pkg::Q_DEPTH);
  assign qstat.empty = fill_r == '0;
  assign rd_rec      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/smm_back.sv
`default_nettype none

module smm_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  smm_pkg::smm_rec_t                          rec,
  input  smm_pkg::smm_qstat_t                        qstat,
  output logic                                       pop,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [smm_pkg::DATA_W-1:0]          out_min_value,
  output logic signed [smm_pkg::DATA_W-1:0]          out_max_value,
  output logic signed [smm_pkg::DATA_W-1:0]          out_mean_value,
  output logic signed [smm_pkg::DATA_W-1:0]          out_midrange_value,
  output logic [smm_pkg::OUT_CNT_W-1:0]              out_item_count,
  output logic                                       out_too_many
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                        state_r, state_nxt;
  logic [smm_pkg::STEP_W-1:0]        step_r;
  logic [smm_pkg::SUM_W-1:0]         dvd_r;
  logic [smm_pkg::CNT_W-1:0]         rem_r;
  logic [smm_pkg::CNT_W-1:0]         div_r;
  logic                              neg_r;
  logic signed [smm_pkg::DATA_W-1:0] min_r;
  logic signed [smm_pkg::DATA_W-1:0] max_r;
  logic signed [smm_pkg::DATA_W-1:0] mean_r;
  logic signed [smm_pkg::DATA_W-1:0] mid_r;
  logic [smm_pkg::CNT_W-1:0]         cnt_r;
  logic                              ovf_r;

  logic [smm_pkg::SUM_W-1:0]         mag;
  logic signed [smm_pkg::DATA_W:0]   mr_sum;
  logic signed [smm_pkg::DATA_W:0]   mr_adj;
  logic [smm_pkg::CNT_W:0]           trial;
  logic                              ge;
  logic [smm_pkg::SUM_W-1:0]         quo_signed;

  assign pop = (state_r == ST_IDLE) && !qstat.empty;

  // Magnitude of the sum; the most negative sum maps onto its unsigned value.
  assign mag = rec.sum[smm_pkg::SUM_W-1] ? -rec.sum : rec.sum;

  // Midrange: 33-bit sum, biased by one when negative so the shift truncates toward zero.
  assign mr_sum = {rec.min_v[smm_pkg::DATA_W-1], rec.min_v}
                + {rec.max_v[smm_pkg::DATA_W-1], rec.max_v};
  assign mr_adj = mr_sum + (smm_pkg::DATA_W + 1)'(mr_sum[smm_pkg::DATA_W]);

  assign trial      = {rem_r, dvd_r[smm_pkg::SUM_W-1]};
  assign ge         = trial >= {1'b0, div_r};
  assign quo_signed = neg_r ? -dvd_r : dvd_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == smm_pkg::STEP_W'(smm_pkg::SUM_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_r <= mag;
      rem_r <= '0;
      div_r <= rec.cnt;
      neg_r <= rec.sum[smm_pkg::SUM_W-1];
      min_r <= rec.min_v;
      max_r <= rec.max_v;
      mid_r <= mr_adj[smm_pkg::DATA_W:1];
      cnt_r <= rec.cnt;
      ovf_r <= rec.ovf;
    end else if (state_r == ST_DIV) begin
      rem_r <= ge ? smm_pkg::CNT_W'(trial - {1'b0, div_r}) : smm_pkg::CNT_W'(trial);
      dvd_r <= {dvd_r[smm_pkg::SUM_W-2:0], ge};
    end
    if (state_r == ST_FIN) begin
      mean_r <= quo_signed[smm_pkg::DATA_W-1:0];
    end
  end

  assign out_valid          = state_r == ST_DONE;
  assign out_min_value      = min_r;
  assign out_max_value      = max_r;
  assign out_mean_value     = mean_r;
  assign out_midrange_value = mid_r;
  assign out_item_count     = smm_pkg::OUT_CNT_W'(cnt_r);
  assign out_too_many       = ovf_r;

endmodule

`default_nettype wire

// File: sv/stream_min_max_mean.sv
`default_nettype none

// Running statistics over sets of signed 32-bit samples. Each input transaction carries one
// sample and a flag that marks the last sample of a set; the last transaction of a set causes
// exactly one result transaction with the minimum, maximum, mean (sum over count, truncated
// toward zero), midrange (max plus min halved, truncated toward zero), the number of samples
// used and a flag that is set when samples beyond the 128-sample limit were dropped. Dropped
// samples still count for closing a set. The accumulator takes one input transaction per cycle
// while the queue has room; a finished set moves into a two-entry queue, and the divide stage
// works through it with a restoring divider that produces one quotient bit per cycle. Each set
// passes through a load, a divide step for each of the 39 sum bits, a sign fix-up and the
// presentation of the result, which holds until the consumer takes it; only then does the stage
// take the next set. Input ready drops only while both queue entries hold finished sets.
module stream_min_max_mean (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [smm_pkg::DATA_W-1:0]   in_sample,
  input  wire logic                                in_last_item,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [smm_pkg::DATA_W-1:0]        out_min_value,
  output logic signed [smm_pkg::DATA_W-1:0]        out_max_value,
  output logic signed [smm_pkg::DATA_W-1:0]        out_mean_value,
  output logic signed [smm_pkg::DATA_W-1:0]        out_midrange_value,
  output logic [smm_pkg::OUT_CNT_W-1:0]            out_item_count,
  output logic                                     out_too_many
);

  logic                   accept;
  logic                   push;
  logic                   pop;
  smm_pkg::smm_rec_t      front_rec;
  smm_pkg::smm_rec_t      queue_rec;
  smm_pkg::smm_qstat_t    qstat;

  // A full queue stalls the front, even for samples that do not close a set.
  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  smm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .sample    (in_sample),
    .last_item (in_last_item),
    .push      (push),
    .rec       (front_rec)
  );

  smm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_rec (front_rec),
    .pop    (pop),
    .rd_rec (queue_rec),
    .qstat  (qstat)
  );

  smm_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec                (queue_rec),
    .qstat              (qstat),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_min_value      (out_min_value),
    .out_max_value      (out_max_value),
    .out_mean_value     (out_mean_value),
    .out_midrange_value (out_midrange_value),
    .out_item_count     (out_item_count),
    .out_too_many       (out_too_many)
  );

`ifndef SYNTH
  // The front must never write a finished set into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qstat.full))
    else $error("set pushed into full queue");

  // The divide stage never takes a set from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qstat.empty))
    else $error("pop from empty queue");

  // A result always covers at least one sample.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item_count != '0)
    else $error("result with zero count");

  // Midrange lies between minimum and maximum.
  a_mid_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_value <= out_midrange_value)
              && (out_midrange_value <= out_max_value))
    else $error("midrange outside min/max");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

// Testbench for stream_min_max_mean. The block condenses each set of signed samples into one
// result transaction. A scoreboard object mirrors the running minimum, maximum, sum and count.
// It queues one expected result per set and compares every accepted result with the oldest
// one it holds. Plain tasks drive the input channel in bursts, and an independent process
// stalls the result channel.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                              W           = smm_pkg::DATA_W;
  localparam logic signed [smm_pkg::DATA_W-1:0] SAMPLE_MAX  = 32'sh7fff_ffff;
  localparam logic signed [smm_pkg::DATA_W-1:0] SAMPLE_MIN  = 32'sh8000_0000;
  localparam int                              CYCLE_LIMIT = 400000;
  localparam int                              TAIL_CYCLES = 120;
  localparam int                              RANDOM_ITEMS = 100;

  typedef logic signed [W-1:0] sample_t;

  // The statistics of one closed set, exactly as the result channel should present them.
  typedef struct {
    sample_t                       min_v;
    sample_t                       max_v;
    sample_t                       mean_v;
    sample_t                       mid_v;
    logic [smm_pkg::OUT_CNT_W-1:0] count;
    logic                          too_many;
  } set_stats_t;

  // Receiver behavior: always ready, ready about half the time, or ready only now and then.
  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  class stats_scoreboard;
    sample_t    run_lo;
    sample_t    run_hi;
    longint     run_total;
    int         run_items;
    bit         dropped;
    set_stats_t pending_sets[$];
    int         errors;

    function new();
      clear_set();
      errors = 0;
    endfunction

    function void clear_set();
      run_lo    = '0;
      run_hi    = '0;
      run_total = 0;
      run_items = 0;
      dropped   = 1'b0;
    endfunction

    // Folds one accepted sample into the running set. A sample that finds the set full is
    // dropped from the statistics, but a last mark on it still closes the set.
    function void note_sample(sample_t s, bit last);
      set_stats_t exp_stats;
      longint     mid_sum;
      if (run_items < smm_pkg::MAX_COUNT) begin
        if (run_items == 0) begin
          run_lo = s;
          run_hi = s;
        end else begin
          if (s < run_lo) run_lo = s;
          if (s > run_hi) run_hi = s;
        end
        run_total += longint'(s);
        run_items++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        // Both divisions truncate toward zero, and the midrange sum is formed wide.
        mid_sum            = longint'(run_hi) + longint'(run_lo);
        exp_stats.min_v    = run_lo;
        exp_stats.max_v    = run_hi;
        exp_stats.mean_v   = sample_t'(run_total / longint'(run_items));
        exp_stats.mid_v    = sample_t'(mid_sum / 2);
        exp_stats.count    = run_items[smm_pkg::OUT_CNT_W-1:0];
        exp_stats.too_many = dropped;
        pending_sets.push_back(exp_stats);
        clear_set();
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_stats(set_stats_t got);
      set_stats_t want;
      if (pending_sets.size() == 0) begin
        $error("result transaction arrived with no closed set pending");
        errors++;
      end else begin
        want = pending_sets.pop_front();
        compare_field("min_value", want.min_v, got.min_v);
        compare_field("max_value", want.max_v, got.max_v);
        compare_field("mean_value", want.mean_v, got.mean_v);
        compare_field("midrange_value", want.mid_v, got.mid_v);
        compare_field("item_count", want.count, got.count);
        compare_field("too_many", want.too_many, got.too_many);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  sample_t                       in_sample;
  logic                          in_last_item;
  logic                          out_valid;
  logic                          out_ready;
  sample_t                       out_min_value;
  sample_t                       out_max_value;
  sample_t                       out_mean_value;
  sample_t                       out_midrange_value;
  logic [smm_pkg::OUT_CNT_W-1:0] out_item_count;
  logic                          out_too_many;

  stats_scoreboard board = new();
  sample_t         set_buf[$];
  int              burst_left;
  int              cycle_count;
  rx_mode_t        rx_mode;
  int              rx_mode_left;

  int set_len_list[3] = '{smm_pkg::MAX_COUNT, smm_pkg::MAX_COUNT + 1, smm_pkg::MAX_COUNT + 3};

  stream_min_max_mean u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_min_value      (out_min_value),
    .out_max_value      (out_max_value),
    .out_mean_value     (out_mean_value),
    .out_midrange_value (out_midrange_value),
    .out_item_count     (out_item_count),
    .out_too_many       (out_too_many)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The watchdog covers the slowest legal run several times over: every set paying the full
  // divide latency plus long receiver stalls, and every sample paying the largest sender gap.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stream_min_max_mean test failed");
      $finish;
    end
  end

  // The receiver changes its mood after random stretches, so stalls land on every phase of
  // the divide stage and of the two-entry queue in front of it.
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_t'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= ($urandom_range(0, 1) == 1);
      default:   out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Results are sampled at the rising edge, where the handshake takes effect.
  always @(posedge clk) begin
    set_stats_t got;
    if (rst_n && out_valid && out_ready) begin
      got.min_v    = out_min_value;
      got.max_v    = out_max_value;
      got.mean_v   = out_mean_value;
      got.mid_v    = out_midrange_value;
      got.count    = out_item_count;
      got.too_many = out_too_many;
      board.check_stats(got);
    end
  end

  // Drives one sample and waits for its transaction. The task is entered and left at a
  // falling edge. At the start of each burst the sender may idle for a random gap; a quarter of
  // the bursts follow the previous one with no gap at all.
  task automatic send_sample(input sample_t s, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s, last);
    @(negedge clk);
  endtask

  // Sends the buffered samples as one set, with the last mark on the final one.
  task automatic send_set();
    for (int i = 0; i < set_buf.size(); i++) begin
      send_sample(set_buf[i], i == set_buf.size() - 1);
    end
    set_buf.delete();
  endtask

  // Holds the sender off until every closed set has produced its result.
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (board.pending_sets.size() != 0);
  endtask

  // Full-range values half of the time, so every sample bit toggles, with small values and
  // values near the extremes mixed in to hit ties, sign changes and wide sums.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 3))
      0, 1:    return sample_t'($urandom);
      2:       return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: begin
        if ($urandom_range(0, 1) == 1) return SAMPLE_MAX - sample_t'($urandom_range(0, 3));
        else return SAMPLE_MIN + sample_t'($urandom_range(0, 3));
      end
    endcase
  endfunction

  initial begin
    int sent;
    int set_len;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_last_item = 1'b0;
    out_ready    = 1'b0;
    rx_mode      = RX_OPEN;
    rx_mode_left = 0;
    burst_left   = 0;
    cycle_count  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single-sample sets at the extremes and around zero.
    set_buf = '{SAMPLE_MAX};                send_set();
    set_buf = '{SAMPLE_MIN};                send_set();
    set_buf = '{32'sd0};                    send_set();
    set_buf = '{-32'sd1};                   send_set();
    // Extremes together: the midrange sum needs the extra bit, and -1 halves to zero.
    set_buf = '{SAMPLE_MAX, SAMPLE_MIN};    send_set();
    set_buf = '{SAMPLE_MIN, SAMPLE_MIN};    send_set();
    set_buf = '{SAMPLE_MAX, SAMPLE_MAX};    send_set();
    // Negative odd results must truncate toward zero, not toward minus infinity.
    set_buf = '{-32'sd7, 32'sd0};           send_set();
    set_buf = '{32'sd7, 32'sd0, 32'sd0};    send_set();
    set_buf = '{-32'sd5, 32'sd3, -32'sd1, 32'sd2};  send_set();
    set_buf = '{SAMPLE_MIN + 32'sd1, SAMPLE_MIN};   send_set();

    // A set that exactly fills the counter, one whose last sample is dropped, and one that
    // overruns by a few samples before closing.
    foreach (set_len_list[k]) begin
      for (int i = 0; i < set_len_list[k]; i++) set_buf.push_back(rand_sample());
      send_set();
    end

    // The sender stops here until the block has delivered everything.
    wait_drained();

    // Random sets: mostly short, some medium, a few near the count limit. Now and then
    // the sender waits for the block to drain between sets.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:          set_len = $urandom_range(smm_pkg::MAX_COUNT - 2, smm_pkg::MAX_COUNT + 4);
        1, 2, 3:    set_len = $urandom_range(13, 60);
        default:    set_len = $urandom_range(1, 12);
      endcase
      for (int i = 0; i < set_len; i++) set_buf.push_back(rand_sample());
      send_set();
      sent += set_len;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    // Give a stray extra result time to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_sets.size() == 0) begin
      $display("stream_min_max_mean test passed");
    end else begin
      $display("stream_min_max_mean test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
